### src/rms_pkg.sv
// shared types and constants for the regret matching strategy unit
package rms_pkg;

  localparam int unsigned LANES     = 4;
  localparam int unsigned SUM_W     = 48;
  localparam int unsigned PROB_W    = 17;
  localparam int unsigned REGRET_W  = 32;
  localparam int unsigned HAND_W    = 10;
  localparam int unsigned REACH_W   = 17;
  localparam int unsigned ITER_W    = 24;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned NACT_W    = 3;
  localparam int unsigned TOTAL_W   = SUM_W + 2;
  localparam int unsigned NUM_W     = SUM_W + 16;
  localparam int unsigned QUOT_W    = 17;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  typedef enum logic [CMD_W-1:0] {
    CMD_STRATEGY   = 2'd0,
    CMD_ACCUMULATE = 2'd1,
    CMD_AVERAGE    = 2'd2,
    CMD_RESERVED   = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [HAND_W-1:0]   hand;
    logic [REGRET_W-1:0] regret_0;
    logic [REGRET_W-1:0] regret_1;
    logic [REGRET_W-1:0] regret_2;
    logic [REGRET_W-1:0] regret_3;
    logic [REACH_W-1:0]  reach_weight;
    logic [ITER_W-1:0]   iter_weight;
  } in_item_t;

  typedef struct packed {
    logic [HAND_W-1:0] hand_out;
    logic [PROB_W-1:0] prob_0;
    logic [PROB_W-1:0] prob_1;
    logic [PROB_W-1:0] prob_2;
    logic [PROB_W-1:0] prob_3;
    logic              uniform_used;
  } out_item_t;

  // lane control from the sequencer
  typedef struct packed {
    logic start;
    logic active;
  } lane_ctrl_t;

  // uniform probability 65536 / n for n in 1..4
  function automatic logic [PROB_W-1:0] uniform_prob(input logic [NACT_W-1:0] n);
    logic [PROB_W-1:0] r;
    unique case (n)
      3'd1:    r = 17'd65536;
      3'd2:    r = 17'd32768;
      3'd3:    r = 17'd21845;
      default: r = 17'd16384;
    endcase
    return r;
  endfunction

endpackage

### src/rms_stream_if.sv
// valid/ready stream interface carrying one payload
interface rms_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### src/rms_lane_div.sv
// one lane: restoring divider giving (num << 16) / den, two bits per cycle
module rms_lane_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rms_pkg::lane_ctrl_t                 ctrl_i,
  input  logic [rms_pkg::SUM_W-1:0]           num_i,
  input  logic [rms_pkg::TOTAL_W-1:0]         den_i,
  output logic [rms_pkg::QUOT_W-1:0]          quot_o,
  output logic                                done_o
);
  localparam int unsigned QW = rms_pkg::QUOT_W;
  localparam int unsigned RW = rms_pkg::TOTAL_W + 1;
  localparam int unsigned NW = rms_pkg::NUM_W;

  logic [NW-1:0]      num_q, num_d;
  logic [RW-1:0]      rem_q, rem_d;
  logic [QW-1:0]      quot_q, quot_d;
  logic [rms_pkg::TOTAL_W-1:0] den_q;
  logic [4:0]         cnt_q, cnt_d;
  logic               busy_q, busy_d;

  // quotient fits in 17 bits, so only the low 17 bits of the shifted numerator
  // (num bit 0 and sixteen zeros) shift through; the upper bits preload the remainder
  always_comb begin
    logic [RW-1:0] r;
    num_d  = num_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    r      = rem_q;
    if (ctrl_i.start) begin
      num_d  = {num_i[0], {(NW-1){1'b0}}};
      rem_d  = RW'(num_i[rms_pkg::SUM_W-1:1]);
      quot_d = '0;
      cnt_d  = 5'(QW);
      busy_d = ctrl_i.active;
    end else if (busy_q) begin
      for (int s = 0; s < 2; s++) begin
        if (cnt_d != 5'd0) begin
          r = {r[RW-2:0], num_d[NW-1]};
          num_d = {num_d[NW-2:0], 1'b0};
          if (r >= RW'(den_q)) begin
            r = r - RW'(den_q);
            quot_d = {quot_d[QW-2:0], 1'b1};
          end else begin
            quot_d = {quot_d[QW-2:0], 1'b0};
          end
          cnt_d = cnt_d - 5'd1;
        end
      end
      rem_d = r;
      if (cnt_d == 5'd0) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
    if (ctrl_i.start) den_q <= den_i;
  end

  assign quot_o = ctrl_i.active ? quot_q : '0;
  assign done_o = !busy_q;
endmodule

### src/regret_matching_strategy_unit.sv
// top level: regret matching with strategy-sum store and lane dividers
// path from acceptance to result valid for cmd 0 and 3: sum, divide start, divide wait,
//   output, the dividers idling when the sum is zero; cmd 1 on a stored hand adds MUL1, MUL2, ACC
//   per active action, cmd 2 adds RD_ADDR and RD_DATA per lane; a held result delays the output
// pacing: one transaction at a time, spaced by the sequencer,
//   the lane dividers (two quotient bits a cycle) and the store's one read port
// reset: control clears at once; then a clearing pass writes zero to all
//   HANDS*MAX_ACTIONS store entries, one a cycle, before the first input is taken
module regret_matching_strategy_unit #(
  parameter int unsigned HANDS       = 1024,
  parameter int unsigned MAX_ACTIONS = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [rms_pkg::NACT_W-1:0]  cfg_wdata_i,
  rms_stream_if.sink                  in_if,
  rms_stream_if.source                out_if
);
  localparam int unsigned DEPTH  = HANDS * MAX_ACTIONS;
  localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LN     = rms_pkg::LANES;
  localparam int unsigned BOUND  = (MAX_ACTIONS < LN) ? MAX_ACTIONS : LN;
  localparam int unsigned SW     = rms_pkg::SUM_W;
  localparam int unsigned PW     = rms_pkg::PROB_W;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_RD_ADDR, ST_RD_DATA, ST_SUM, ST_DIV, ST_WAITDIV,
    ST_MUL1, ST_MUL2, ST_ACC, ST_OUT
  } state_e;

  state_e state_q;

  // store: entry hand*MAX_ACTIONS + a
  logic [SW-1:0] mem [DEPTH];
  logic [SW-1:0] rdata_q;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [SW-1:0] wdata;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  logic [rms_pkg::NACT_W-1:0] nact_q;
  logic [rms_pkg::NACT_W-1:0] n_eff;
  rms_pkg::in_item_t          item_q;
  logic [AW:0]                clr_q;
  logic [2:0]                 lane_q;
  logic [SW-1:0]              val_q [LN];
  logic [rms_pkg::TOTAL_W-1:0] total_q;
  logic                       in_store_q;
  logic [AW-1:0]              base_q;
  logic [PW-1:0]              prob_q [LN];
  logic                       uni_q;
  logic [40:0]                prod1_q;
  logic [57:0]                prod2_q;
  logic                       out_valid_q;
  rms_pkg::out_item_t         out_q;
  logic                       start;
  logic [LN-1:0]              done;
  logic [rms_pkg::QUOT_W-1:0] quot [LN];
  logic [LN-1:0]              lane_act;

  // clamp the register to 1..BOUND
  always_comb begin
    if (nact_q == 3'd0) n_eff = 3'd1;
    else if (32'(nact_q) > BOUND) n_eff = 3'(BOUND);
    else n_eff = nact_q;
  end

  for (genvar g = 0; g < LN; g++) begin : g_lane
    rms_pkg::lane_ctrl_t ctrl;
    assign lane_act[g] = (32'(g) < 32'(n_eff)) && (total_q != '0);
    assign ctrl.start  = start;
    assign ctrl.active = lane_act[g];
    rms_lane_div u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .num_i  (val_q[g]),
      .den_i  (total_q),
      .quot_o (quot[g]),
      .done_o (done[g])
    );
  end

  logic [1:0]    lane_ix;
  logic [AW-1:0] lane_addr;
  logic [SW:0]   acc_sum;
  assign lane_ix   = lane_q[1:0];
  assign lane_addr = base_q + AW'(lane_ix);
  assign acc_sum   = {1'b0, rdata_q} + (SW+1)'(prod2_q[57:32]);

  // the store entry of the lane is read in the multiply cycle just before its write
  assign start = (state_q == ST_DIV);
  assign raddr = (state_q == ST_RD_ADDR || state_q == ST_MUL2) ? lane_addr : '0;
  assign we    = (state_q == ST_CLEAR) || (state_q == ST_ACC);
  assign waddr = (state_q == ST_CLEAR) ? clr_q[AW-1:0] : lane_addr;
  assign wdata = (state_q == ST_CLEAR) ? '0 :
                 (acc_sum[SW] ? rms_pkg::SUM_MAX : acc_sum[SW-1:0]);

  // the output register parts the sides: a held result does not block taking the next input, only the next result
  assign in_if.ready  = (state_q == ST_IDLE);
  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nact_q <= 3'd4;
    end else if (cfg_we_i) begin
      nact_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      lane_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_OUT && (!out_valid_q || out_if.ready)) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          // clearing pass over the store
          clr_q <= clr_q + 1'b1;
          if (clr_q == (AW+1)'(DEPTH - 1)) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_if.valid && in_if.ready) begin
            item_q     <= in_if.data;
            in_store_q <= 32'(in_if.data.hand) < HANDS;
            base_q     <= AW'(32'(in_if.data.hand) * MAX_ACTIONS);
            lane_q     <= '0;
            for (int a = 0; a < LN; a++) begin
              logic [31:0] r;
              r = (a == 0) ? in_if.data.regret_0 : (a == 1) ? in_if.data.regret_1 :
                  (a == 2) ? in_if.data.regret_2 : in_if.data.regret_3;
              val_q[a] <= (r[31] || a >= 32'(n_eff)) ? '0 : SW'(r);
            end
            if (in_if.data.cmd == rms_pkg::CMD_AVERAGE) state_q <= ST_RD_ADDR;
            else state_q <= ST_SUM;
          end
        end
        ST_RD_ADDR: state_q <= ST_RD_DATA;
        ST_RD_DATA: begin
          val_q[lane_ix] <= (in_store_q && 32'(lane_ix) < 32'(n_eff)) ? rdata_q : '0;
          lane_q <= lane_q + 3'd1;
          state_q <= (lane_q == 3'(LN - 1)) ? ST_SUM : ST_RD_ADDR;
        end
        ST_SUM: begin
          total_q <= rms_pkg::TOTAL_W'(val_q[0]) + rms_pkg::TOTAL_W'(val_q[1])
                   + rms_pkg::TOTAL_W'(val_q[2]) + rms_pkg::TOTAL_W'(val_q[3]);
          state_q <= ST_DIV;
        end
        ST_DIV: state_q <= ST_WAITDIV;
        ST_WAITDIV: begin
          if (&done) begin
            uni_q <= (total_q == '0);
            for (int a = 0; a < LN; a++) begin
              if (a >= 32'(n_eff)) prob_q[a] <= '0;
              else if (total_q == '0) prob_q[a] <= rms_pkg::uniform_prob(n_eff);
              else prob_q[a] <= quot[a];
            end
            lane_q <= '0;
            if (item_q.cmd == rms_pkg::CMD_ACCUMULATE && in_store_q) state_q <= ST_MUL1;
            else state_q <= ST_OUT;
          end
        end
        ST_MUL1: begin
          prod1_q <= 41'(item_q.reach_weight) * 41'(item_q.iter_weight);
          state_q <= ST_MUL2;
        end
        ST_MUL2: begin
          prod2_q <= 58'(prod1_q) * 58'(prob_q[lane_ix]);
          state_q <= ST_ACC;
        end
        ST_ACC: begin
          lane_q <= lane_q + 3'd1;
          state_q <= (lane_q + 3'd1 >= n_eff) ? ST_OUT : ST_MUL1;
        end
        ST_OUT: begin
          if (!out_valid_q || out_if.ready) begin
            out_q.hand_out     <= item_q.hand;
            out_q.prob_0       <= prob_q[0];
            out_q.prob_1       <= prob_q[1];
            out_q.prob_2       <= prob_q[2];
            out_q.prob_3       <= prob_q[3];
            out_q.uniform_used <= uni_q;
            state_q            <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.ready |-> state_q == ST_IDLE) else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.data))
    else $error("result dropped");
  a_uni_probs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.data.uniform_used |-> out_if.data.prob_0 != '0)
    else $error("uniform result with zero lane 0");
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !we) else $error("store written while idle");
`endif
endmodule

### tb/tb_regret_matching_strategy_unit.sv
// testbench for the regret matching strategy unit: directed and random stimulus with a scoreboard
`timescale 1ns / 100ps

module tb_regret_matching_strategy_unit;

  localparam int unsigned N_HANDS   = 1024;
  localparam int unsigned N_ACTIONS = 4;
  localparam int unsigned N_ITEMS   = 1800;
  localparam longint     CYCLE_LIMIT = 1000000;

  // scoreboard: own copy of the strategy-sum store and the active action count
  class strategy_scoreboard;
    logic [rms_pkg::SUM_W-1:0] sum_store [N_HANDS*N_ACTIONS];
    logic [rms_pkg::NACT_W-1:0] n_actions_reg;
    rms_pkg::out_item_t pending_q[$];
    int unsigned errors;
    int unsigned checked;

    function void clear_state();
      foreach (sum_store[i]) sum_store[i] = '0;
      n_actions_reg = 3'd4;
      errors = 0;
      checked = 0;
    endfunction

    function int unsigned lanes_active();
      int unsigned n;
      n = n_actions_reg;
      if (n < 1) n = 1;
      if (n > N_ACTIONS) n = N_ACTIONS;
      return n;
    endfunction

    // divide each lane by the lane total, uniform if the total is zero
    function void share_out(input logic [63:0] val[rms_pkg::LANES], input int unsigned n,
                            output logic [63:0] prob[rms_pkg::LANES], output logic uni);
      logic [63:0] total;
      total = 0;
      for (int a = 0; a < n; a++) total += val[a];
      for (int a = 0; a < rms_pkg::LANES; a++) prob[a] = 0;
      uni = (total == 0);
      for (int a = 0; a < n; a++)
        prob[a] = uni ? 64'(65536 / n) : (val[a] << 16) / total;
    endfunction

    // note an accepted input transaction and push its expected result
    function void note_input(input rms_pkg::in_item_t it);
      logic [63:0] val[rms_pkg::LANES];
      logic [63:0] prob[rms_pkg::LANES];
      logic [rms_pkg::REGRET_W-1:0] reg_v[rms_pkg::LANES];
      logic [63:0] add, s;
      logic uni;
      int unsigned n, base;
      bit in_store;
      rms_pkg::out_item_t exp_item;
      n = lanes_active();
      in_store = it.hand < N_HANDS;
      base = in_store ? it.hand * N_ACTIONS : 0;
      reg_v = '{it.regret_0, it.regret_1, it.regret_2, it.regret_3};
      for (int a = 0; a < rms_pkg::LANES; a++) begin
        if (it.cmd == rms_pkg::CMD_AVERAGE)
          val[a] = (in_store && a < n) ? 64'(sum_store[base+a]) : 0;
        else
          val[a] = (a < n && !reg_v[a][rms_pkg::REGRET_W-1]) ? 64'(reg_v[a]) : 0;
      end
      share_out(val, n, prob, uni);
      if (it.cmd == rms_pkg::CMD_ACCUMULATE && in_store) begin
        for (int a = 0; a < n; a++) begin
          add = (64'(it.reach_weight) * 64'(it.iter_weight) * prob[a]) >> 32;
          s = 64'(sum_store[base+a]) + add;
          if (s > 64'(rms_pkg::SUM_MAX)) s = 64'(rms_pkg::SUM_MAX);
          sum_store[base+a] = s[rms_pkg::SUM_W-1:0];
        end
      end
      exp_item.hand_out = it.hand;
      exp_item.prob_0 = prob[0][rms_pkg::PROB_W-1:0];
      exp_item.prob_1 = prob[1][rms_pkg::PROB_W-1:0];
      exp_item.prob_2 = prob[2][rms_pkg::PROB_W-1:0];
      exp_item.prob_3 = prob[3][rms_pkg::PROB_W-1:0];
      exp_item.uniform_used = uni;
      pending_q.push_back(exp_item);
    endfunction

    // compare a result transaction with the oldest expectation
    function void check_result(input rms_pkg::out_item_t got);
      rms_pkg::out_item_t e;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result transaction %h", $realtime, got);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      checked++;
      if (got.hand_out !== e.hand_out) begin
        $display("%0t: hand_out expected %0d actual %0d", $realtime, e.hand_out, got.hand_out);
        errors++;
      end
      if (got.prob_0 !== e.prob_0) begin
        $display("%0t: prob_0 expected %0d actual %0d", $realtime, e.prob_0, got.prob_0);
        errors++;
      end
      if (got.prob_1 !== e.prob_1) begin
        $display("%0t: prob_1 expected %0d actual %0d", $realtime, e.prob_1, got.prob_1);
        errors++;
      end
      if (got.prob_2 !== e.prob_2) begin
        $display("%0t: prob_2 expected %0d actual %0d", $realtime, e.prob_2, got.prob_2);
        errors++;
      end
      if (got.prob_3 !== e.prob_3) begin
        $display("%0t: prob_3 expected %0d actual %0d", $realtime, e.prob_3, got.prob_3);
        errors++;
      end
      if (got.uniform_used !== e.uniform_used) begin
        $display("%0t: uniform_used expected %0b actual %0b", $realtime,
                 e.uniform_used, got.uniform_used);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [rms_pkg::NACT_W-1:0] cfg_wdata_i = '0;
  longint cycle_count = 0;
  bit stall_long = 1'b0;  // raised by the sender to ask for a long receiver hold-off
  int unsigned cmd_seen[4];

  rms_stream_if #(.payload_t(rms_pkg::in_item_t))  in_if ();
  rms_stream_if #(.payload_t(rms_pkg::out_item_t)) out_if ();

  strategy_scoreboard sb;

  regret_matching_strategy_unit #(
    .HANDS       (N_HANDS),
    .MAX_ACTIONS (N_ACTIONS)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (in_if),
    .out_if      (out_if)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // watchdog: the limit leaves wide margin over the reset clear pass of 4096 store
  // entries and every transaction with long gaps on both sides
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
  end

  // half the time no gap, else mostly a short gap and now and then a long one
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side: random hold-off gaps, one long hold-off when the sender asks for it
  initial begin
    int unsigned hold;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) sb.check_result(out_if.data);
      if (stall_long) begin
        out_if.ready <= 1'b0;
        for (int i = 0; i < 300; i++) @(posedge clk_i);
        stall_long = 1'b0;
        out_if.ready <= 1'b1;
      end else begin
        hold = gap_len();
        if (hold != 0) begin
          out_if.ready <= 1'b0;
          repeat (hold) @(posedge clk_i);
        end
        out_if.ready <= 1'b1;
      end
    end
  end

  // offer one input transaction and wait until it is taken
  task automatic send_item(input rms_pkg::in_item_t it);
    int unsigned g;
    g = gap_len();
    if (g != 0) begin
      in_if.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= it;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_input(it);
    cmd_seen[it.cmd]++;
  endtask

  // drop valid, drain outstanding results, settle, then write the register
  task automatic write_actions(input logic [rms_pkg::NACT_W-1:0] v);
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.n_actions_reg = v;
  endtask

  function automatic logic [rms_pkg::REGRET_W-1:0] rand_regret();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      3: return $urandom_range(0, 32'h0003_FFFF);
      4: return -$urandom_range(0, 32'h0003_FFFF);
      default: return $urandom;
    endcase
  endfunction

  function automatic rms_pkg::in_item_t make_item(input rms_pkg::cmd_e c,
                                                  input logic [rms_pkg::HAND_W-1:0] h);
    rms_pkg::in_item_t it;
    it.cmd = c;
    it.hand = h;
    it.regret_0 = rand_regret();
    it.regret_1 = rand_regret();
    it.regret_2 = rand_regret();
    it.regret_3 = rand_regret();
    it.reach_weight = ($urandom_range(0, 9) == 0) ? rms_pkg::REACH_W'($urandom) :
                      rms_pkg::REACH_W'($urandom_range(0, 65536));
    it.iter_weight = rms_pkg::ITER_W'($urandom);
    return it;
  endfunction

  initial begin
    rms_pkg::in_item_t it;
    logic [rms_pkg::NACT_W-1:0] settings[8];
    rms_pkg::cmd_e c;
    sb = new();
    sb.clear_state();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes of every field, every cmd
    it = '{cmd: rms_pkg::CMD_STRATEGY, hand: 0, regret_0: 0, regret_1: 0, regret_2: 0,
           regret_3: 0, reach_weight: 0, iter_weight: 0};
    send_item(it);  // all-zero regrets take the uniform path
    it = '{cmd: rms_pkg::CMD_STRATEGY, hand: 10'h3FF, regret_0: 32'h7FFF_FFFF,
           regret_1: 32'h8000_0000, regret_2: 32'hFFFF_FFFF, regret_3: 1,
           reach_weight: 17'h1FFFF, iter_weight: 24'hFFFFFF};
    send_item(it);
    it.cmd = rms_pkg::CMD_RESERVED;
    send_item(it);
    it = '{cmd: rms_pkg::CMD_AVERAGE, hand: 5, regret_0: 0, regret_1: 0, regret_2: 0,
           regret_3: 0, reach_weight: 0, iter_weight: 0};
    send_item(it);  // empty store entry averages to uniform
    // pile full-weight accumulates on one hand
    for (int i = 0; i < 6; i++) begin
      it = '{cmd: rms_pkg::CMD_ACCUMULATE, hand: 7, regret_0: 32'h7FFF_FFFF, regret_1: 0,
             regret_2: 0, regret_3: 0, reach_weight: 17'h1FFFF,
             iter_weight: 24'hFFFFFF};
      send_item(it);
    end
    it.cmd = rms_pkg::CMD_AVERAGE;
    send_item(it);
    it = '{cmd: rms_pkg::CMD_ACCUMULATE, hand: 9, regret_0: 32'h0001_0000,
           regret_1: 32'h0003_0000, regret_2: 32'hFFFF_0000, regret_3: 32'h0002_0000,
           reach_weight: 17'd65536, iter_weight: 24'h010000};
    send_item(it);
    it.cmd = rms_pkg::CMD_AVERAGE;
    send_item(it);

    // register sweep: extremes and out-of-range values, random traffic in each
    settings = '{3'd1, 3'd0, 3'd4, 3'd2, 3'd7, 3'd3, 3'd5, 3'd4};
    foreach (settings[s]) begin
      write_actions(settings[s]);
      for (int i = 0; i < N_ITEMS / 8; i++) begin
        // a pool of 16 hands for nine in ten items keeps the averages meaningful
        c = rms_pkg::cmd_e'($urandom_range(0, 9) < 4 ? rms_pkg::CMD_ACCUMULATE :
                            $urandom_range(0, 2) == 0 ? rms_pkg::CMD_AVERAGE :
                            $urandom_range(0, 4) == 0 ? rms_pkg::CMD_RESERVED :
                            rms_pkg::CMD_STRATEGY);
        it = make_item(c, ($urandom_range(0, 9) == 0) ? rms_pkg::HAND_W'($urandom) :
                          rms_pkg::HAND_W'($urandom_range(0, 15)));
        if (s == 2 && i == 20) stall_long = 1'b1;  // fill the block while results wait
        send_item(it);
      end
    end

    in_if.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("covered %0d results over 8 action-count settings (cmd 0/1/2/3: %0d/%0d/%0d/%0d)",
             sb.checked, cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3]);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
